[sv/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probing hash table
// Table geometry, derived widths, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // table geometry
    localparam int TABLE_SIZE = 13;
    localparam int KEY_W      = 16;
    localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int ACC_W      = SLOT_W + 1;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;

    // home slot by reciprocal multiply: quotient = (key * HASH_MUL) >> HASH_SHIFT,
    // exact for every 16-bit key while TABLE_SIZE stays at or below 256
    localparam int HASH_SHIFT  = 24;
    localparam int HASH_MUL_W  = HASH_SHIFT;
    localparam int HASH_PROD_W = KEY_W + HASH_MUL_W;
    localparam logic [HASH_MUL_W-1:0] HASH_MUL =
        HASH_MUL_W'(((64'd1 << HASH_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [SLOT_W-1:0]    slot_idx_t;
    typedef logic [ACC_W-1:0]     acc_t;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_DELETED   = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_QUOT  = 3'd1,
        ST_HASH  = 3'd2,
        ST_PROBE = 3'd3,
        ST_DONE  = 3'd4
    } state_t;

endpackage

[sv/lpht_ram.sv]
// ----------------------------------------------------------------------------
// lpht_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/lpht_mod_unit.sv]
// ----------------------------------------------------------------------------
// lpht_mod_unit: conditional-subtract unit
// Reduces a value below twice the table size into the slot range. Serves
// the wrapping probe increment.
// ----------------------------------------------------------------------------
module lpht_mod_unit (
    input  lpht_pkg::acc_t      a,
    output lpht_pkg::slot_idx_t r
);

    localparam lpht_pkg::acc_t SIZE_ACC = lpht_pkg::ACC_W'(lpht_pkg::TABLE_SIZE);

    lpht_pkg::acc_t diff;

    // one compare and subtract
    always_comb
    begin
        diff = a - SIZE_ACC;
        if (a >= SIZE_ACC)
        begin
            r = lpht_pkg::SLOT_W'(diff);
        end
        else
        begin
            r = lpht_pkg::SLOT_W'(a);
        end
    end

endmodule

[sv/linear_probe_hash_table_core.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: open-addressed hash table, linear probing
// Insert and delete of 16-bit keys; one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, command, key): one command per transfer,
//   command 0 inserts the key, command 1 deletes the first matching entry.
//   Output channel (out_valid/out_ready, status, slot): one result per command,
//   in command order.
//   Timing: after an input transfer a reciprocal multiply and a
//   multiply-subtract give the home slot, then slots are probed one per
//   cycle, up to TABLE_SIZE slots, through the key memory's registered
//   read port, then the result is staged. in_ready is low meanwhile, so the
//   block takes no new command before the last one's result is staged.
//   The output register holds one finished result; the next command is taken
//   while it waits. If the receiver stalls longer, the block holds the new
//   result in its staging register and stays busy until the output frees.
//   Reset clears all slot valid bits, the sequencer and the output valid
//   flag; in_ready is high from reset on.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [15:0] key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  slot
);

    localparam lpht_pkg::slot_idx_t LAST_PROBE =
        lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1);

    lpht_pkg::state_t    state_reg, state_next;
    logic                cmd_reg, cmd_next;
    lpht_pkg::key_t      key_reg, key_next;
    lpht_pkg::key_t      quot_reg, quot_next;
    lpht_pkg::slot_idx_t pos_reg, pos_next;
    lpht_pkg::slot_idx_t probe_cnt_reg, probe_cnt_next;
    logic [lpht_pkg::TABLE_SIZE-1:0] valid_reg, valid_next;
    lpht_pkg::status_t   res_status_reg, res_status_next;
    lpht_pkg::slot_idx_t res_slot_reg, res_slot_next;
    logic                out_valid_reg, out_valid_next;
    lpht_pkg::status_t   out_status_reg, out_status_next;
    logic [3:0]          out_slot_reg, out_slot_next;

    lpht_pkg::acc_t      unit_a;
    lpht_pkg::slot_idx_t unit_r;
    lpht_pkg::key_t      rd_key;
    logic [lpht_pkg::HASH_PROD_W-1:0] recip_prod;
    lpht_pkg::key_t      quot_times_size;
    lpht_pkg::key_t      hash_rem;
    logic                ram_we;
    logic                in_xfer;
    logic                out_free;
    logic                hit;

    // compare-subtract unit
    lpht_mod_unit u_mod (
        .a (unit_a),
        .r (unit_r)
    );

    // key store, read address is the next probe position, so the registered read data matches the current one
    lpht_ram #(
        .WIDTH (lpht_pkg::KEY_W),
        .DEPTH (lpht_pkg::TABLE_SIZE)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (key_reg),
        .raddr (pos_next),
        .rdata (rd_key)
    );

    assign in_ready = (state_reg == lpht_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // probe match for the current slot
    always_comb
    begin
        if (cmd_reg == lpht_pkg::CMD_INSERT)
        begin
            hit = !valid_reg[pos_reg];
        end
        else
        begin
            hit = valid_reg[pos_reg] && (rd_key == key_reg);
        end
    end

    // home slot arithmetic: reciprocal quotient, then key minus quotient times size
    always_comb
    begin
        recip_prod      = lpht_pkg::HASH_PROD_W'(key_reg) *
                          lpht_pkg::HASH_PROD_W'(lpht_pkg::HASH_MUL);
        quot_times_size = quot_reg * lpht_pkg::KEY_W'(lpht_pkg::TABLE_SIZE);
        hash_rem        = key_reg - quot_times_size;
    end

    // unit operand: wrapping probe increment
    assign unit_a = lpht_pkg::ACC_W'(pos_reg) + lpht_pkg::ACC_W'(1);

    // sequencer next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        quot_next       = quot_reg;
        pos_next        = pos_reg;
        probe_cnt_next  = probe_cnt_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        ram_we          = 1'b0;

        // output register drains on a transfer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lpht_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = command;
                    key_next   = key;
                    state_next = lpht_pkg::ST_QUOT;
                end
            end

            lpht_pkg::ST_QUOT:
            begin
                // quotient of key by table size
                quot_next  = recip_prod[lpht_pkg::HASH_SHIFT +: lpht_pkg::KEY_W];
                state_next = lpht_pkg::ST_HASH;
            end

            lpht_pkg::ST_HASH:
            begin
                // remainder is the home slot, always below table size
                pos_next       = lpht_pkg::SLOT_W'(hash_rem);
                probe_cnt_next = '0;
                state_next     = lpht_pkg::ST_PROBE;
            end

            lpht_pkg::ST_PROBE:
            begin
                if (hit)
                begin
                    res_slot_next = pos_reg;
                    if (cmd_reg == lpht_pkg::CMD_INSERT)
                    begin
                        ram_we              = 1'b1;
                        valid_next[pos_reg] = 1'b1;
                        res_status_next     = lpht_pkg::STATUS_INSERTED;
                    end
                    else
                    begin
                        valid_next[pos_reg] = 1'b0;
                        res_status_next     = lpht_pkg::STATUS_DELETED;
                    end
                    state_next = lpht_pkg::ST_DONE;
                end
                else if (probe_cnt_reg == LAST_PROBE)
                begin
                    res_slot_next = '0;
                    if (cmd_reg == lpht_pkg::CMD_INSERT)
                    begin
                        res_status_next = lpht_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        res_status_next = lpht_pkg::STATUS_NOT_FOUND;
                    end
                    state_next = lpht_pkg::ST_DONE;
                end
                else
                begin
                    pos_next       = unit_r;
                    probe_cnt_next = probe_cnt_reg + lpht_pkg::SLOT_W'(1);
                end
            end

            lpht_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = 4'(res_slot_reg);
                    state_next      = lpht_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lpht_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        quot_reg       <= quot_next;
        pos_reg        <= pos_next;
        probe_cnt_reg  <= probe_cnt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign slot      = out_slot_reg;

`ifndef ASSERT_OFF
    // a command transfer makes the block busy in the next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after a command transfer");

    // full and not found results carry slot zero
    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lpht_pkg::STATUS_FULL ||
                      status == lpht_pkg::STATUS_NOT_FOUND) |-> slot == 4'd0)
        else $error("miss result with nonzero slot");

    // an insert hit marks its slot valid
    a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lpht_pkg::ST_PROBE && hit && cmd_reg == lpht_pkg::CMD_INSERT
        |=> valid_reg[$past(pos_reg)])
        else $error("inserted slot not marked valid");

    // probe count stays inside the table
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lpht_pkg::ST_PROBE |-> probe_cnt_reg <= LAST_PROBE)
        else $error("probe count past table size");
`endif

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for linear_probe_hash_table_core
// Drives insert and delete commands over the input channel and keeps its own
// copy of the slot table to predict each status and slot. Results are checked
// in order against that prediction while both channels stall at random outside the back-to-back test.
// ----------------------------------------------------------------------------
module tb_top;
    import lpht_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_OUT_W-1:0]   slot_num;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [15:0] key;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  slot;

    // shadow copy of the table
    key_t table_keys [TABLE_SIZE];
    logic table_used [TABLE_SIZE];

    table_result_t pending_results [$];
    int            mismatch_count = 0;
    int            result_count = 0;
    bit            no_idle = 1'b0;

    linear_probe_hash_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot      (slot)
    );

    always #5 clk = ~clk;

    // run the command on the shadow table and return the answer it gives
    function automatic table_result_t apply_table_op(logic cmd, key_t k);
        table_result_t res;
        int            pos;
        bit            done;
        pos          = int'(k) % TABLE_SIZE;
        done         = 1'b0;
        res.slot_num = '0;
        if (cmd == CMD_INSERT)
        begin
            res.status = STATUS_FULL;
            for (int n = 0; n < TABLE_SIZE && !done; n++)
            begin
                if (!table_used[pos])
                begin
                    table_keys[pos] = k;
                    table_used[pos] = 1'b1;
                    res.status      = STATUS_INSERTED;
                    res.slot_num    = SLOT_OUT_W'(pos);
                    done            = 1'b1;
                end
                else
                begin
                    pos = (pos + 1) % TABLE_SIZE;
                end
            end
        end
        else
        begin
            res.status = STATUS_NOT_FOUND;
            for (int n = 0; n < TABLE_SIZE && !done; n++)
            begin
                // a cleared slot keeps its key but no longer matches
                if (table_used[pos] && table_keys[pos] == k)
                begin
                    table_used[pos] = 1'b0;
                    res.status      = STATUS_DELETED;
                    res.slot_num    = SLOT_OUT_W'(pos);
                    done            = 1'b1;
                end
                else
                begin
                    pos = (pos + 1) % TABLE_SIZE;
                end
            end
        end
        return res;
    endfunction

    // keys: full range, clustered on a few home slots, or a tiny set for duplicates
    function automatic key_t pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return key_t'($urandom_range(0, 65535));
        if (sel < 8)
            return key_t'($urandom_range(0, 2) + TABLE_SIZE * $urandom_range(0, 5040));
        return key_t'($urandom_range(0, 31));
    endfunction

    // mostly a key that is stored right now, so deletes hit
    function automatic key_t pick_delete_key();
        int stored;
        int pick;
        stored = 0;
        foreach (table_used[i])
            if (table_used[i])
                stored++;
        if (stored != 0 && $urandom_range(0, 99) < 65)
        begin
            pick = $urandom_range(0, stored - 1);
            foreach (table_used[i])
            begin
                if (table_used[i])
                begin
                    if (pick == 0)
                        return table_keys[i];
                    pick--;
                end
            end
        end
        return pick_key();
    endfunction

    // one input transfer; valid stays up so the next call can follow at once
    task automatic send_op(logic cmd, key_t k);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_table_op(cmd, k));
    endtask

    task automatic send_random_op(int insert_pct);
        if ($urandom_range(1, 100) <= insert_pct)
            send_op(CMD_INSERT, pick_key());
        else
            send_op(CMD_DELETE, pick_delete_key());
    endtask

    // drop valid and hold off until every answer is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_directed_edges();
        // delete from an empty table
        send_op(CMD_DELETE, 16'h0000);
        // extreme keys and a collision that wraps past the last slot
        send_op(CMD_INSERT, 16'hffff);
        send_op(CMD_INSERT, 16'h0000);
        send_op(CMD_INSERT, 16'd12);
        send_op(CMD_INSERT, 16'd25);
        // fill the rest of the table
        for (int h = 3; h < TABLE_SIZE - 1; h++)
            send_op(CMD_INSERT, key_t'(TABLE_SIZE * h * 411 + h));
        // insert into a full table
        send_op(CMD_INSERT, 16'd7);
        // delete, then delete again from the cleared slot
        send_op(CMD_DELETE, 16'd25);
        send_op(CMD_DELETE, 16'd25);
        // duplicate key, deleted from its home first
        send_op(CMD_INSERT, 16'd12);
        send_op(CMD_DELETE, 16'd12);
        send_op(CMD_DELETE, 16'd12);
        send_op(CMD_DELETE, 16'hffff);
        send_op(CMD_INSERT, 16'hffff);
        // home slot held by another key
        send_op(CMD_DELETE, 16'd3);
    endtask

    task automatic test_random_mix(int n_items);
        int insert_pct;
        insert_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            // shift the insert/delete balance so the fill level wanders
            if (i % 100 == 0)
                insert_pct = $urandom_range(20, 85);
            if (i == n_items / 2)
                wait_for_results();
            send_random_op(insert_pct);
        end
    endtask

    task automatic test_back_to_back(int n_items);
        no_idle = 1'b1;
        for (int i = 0; i < n_items; i++)
            send_random_op(55);
    endtask

    // receiver stalls in bursts
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!no_idle && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: result %0d with nothing predicted: status %0d slot %0d",
                             result_count, status, slot);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || slot !== want.slot_num)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tb: result %0d: expected status %0d slot %0d, got status %0d slot %0d",
                                 result_count, want.status, want.slot_num, status, slot);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        in_valid <= 1'b0;
        command  <= CMD_INSERT;
        key      <= '0;
        foreach (table_used[i])
        begin
            table_used[i] = 1'b0;
            table_keys[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        wait_for_results();
        test_random_mix(1000);
        test_back_to_back(150);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
